[hdl/pir_pkg.sv]
// Shared types and constants for the clamped PI regulator.
// Holds the configuration record, register indexes and reset values.
// No dependencies.
package pir_pkg;

  // Fixed widths of the limit registers and the Q4.12 gains.
  localparam int LIMIT_W    = 12;
  localparam int GAIN_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX       = 3'd4;

  // Reset values of the registers.
  localparam logic [LIMIT_W-1:0]       SETPOINT_RST      = 12'h7FF;
  localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST     = 16'sd6554;
  localparam logic signed [GAIN_W-1:0] INTEGRAL_GAIN_RST = 16'sd0;
  localparam logic [LIMIT_W-1:0]       OUT_MIN_RST       = 12'd0;
  localparam logic [LIMIT_W-1:0]       OUT_MAX_RST       = 12'd3000;

  // Current configuration as seen by the datapath.
  typedef struct packed {
    logic [LIMIT_W-1:0]       setpoint;
    logic signed [GAIN_W-1:0] prop_gain;
    logic signed [GAIN_W-1:0] integral_gain;
    logic [LIMIT_W-1:0]       out_min;
    logic [LIMIT_W-1:0]       out_max;
  } cfg_t;

endpackage

[hdl/pir_cfg_regs.sv]
// Configuration register file of the clamped PI regulator.
// Depends on pir_pkg for the register indexes, reset values and cfg_t.
module pir_cfg_regs import pir_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the write; unknown indexes leave every register unchanged.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SETPOINT:      cfg_d.setpoint      = cfg_wdata_i[LIMIT_W-1:0];
        REG_PROP_GAIN:     cfg_d.prop_gain     = $signed(cfg_wdata_i[GAIN_W-1:0]);
        REG_INTEGRAL_GAIN: cfg_d.integral_gain = $signed(cfg_wdata_i[GAIN_W-1:0]);
        REG_OUT_MIN:       cfg_d.out_min       = cfg_wdata_i[LIMIT_W-1:0];
        REG_OUT_MAX:       cfg_d.out_max       = cfg_wdata_i[LIMIT_W-1:0];
        default:           cfg_d               = cfg_q;
      endcase
    end
  end

  // Register storage with the documented reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.setpoint      <= SETPOINT_RST;
      cfg_q.prop_gain     <= PROP_GAIN_RST;
      cfg_q.integral_gain <= INTEGRAL_GAIN_RST;
      cfg_q.out_min       <= OUT_MIN_RST;
      cfg_q.out_max       <= OUT_MAX_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hdl/pir_trunc_clamp.sv]
// Truncation toward zero of a fixed-point sum, then clamping to the limits.
// Depends on pir_pkg for LIMIT_W.
module pir_trunc_clamp import pir_pkg::*; #(
  parameter int ACC_W     = 35,
  parameter int FRAC_BITS = 12
) (
  input  logic signed [ACC_W-1:0] acc_i,
  input  logic [LIMIT_W-1:0]      out_min_i,
  input  logic [LIMIT_W-1:0]      out_max_i,
  output logic [LIMIT_W-1:0]      value_o
);

  localparam logic [ACC_W-1:0] FRAC_MASK = {{(ACC_W-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

  logic signed [ACC_W-1:0] biased;
  logic signed [ACC_W-1:0] whole;
  logic signed [ACC_W-1:0] lim_min;
  logic signed [ACC_W-1:0] lim_max;

  // A negative sum gets the fraction mask added so the arithmetic shift
  // rounds toward zero instead of toward minus infinity.
  always_comb begin
    biased  = acc_i + $signed(acc_i[ACC_W-1] ? FRAC_MASK : {ACC_W{1'b0}});
    whole   = biased >>> FRAC_BITS;
    lim_min = $signed({{(ACC_W-LIMIT_W){1'b0}}, out_min_i});
    lim_max = $signed({{(ACC_W-LIMIT_W){1'b0}}, out_max_i});
  end

  // The upper limit is checked first: with inverted limits a value above it gets out_max, any other gets out_min.
  always_comb begin
    if (whole > lim_max) begin
      value_o = out_max_i;
    end else if (whole < lim_min) begin
      value_o = out_min_i;
    end else begin
      value_o = whole[LIMIT_W-1:0];
    end
  end

endmodule

[hdl/pir_product_stage.sv]
// First pipeline stage: control error and both gain products.
// Depends on pir_pkg for cfg_t and the gain width.
module pir_product_stage import pir_pkg::*; #(
  parameter int SAMPLE_BITS = 12,
  parameter int ERR_W       = 13,
  parameter int PROD_W      = 29
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [SAMPLE_BITS-1:0]   sample_i,
  input  cfg_t                     cfg_i,
  output logic signed [PROD_W-1:0] prop_prod_o,
  output logic signed [PROD_W-1:0] int_prod_o
);

  logic [ERR_W-2:0]          sp_ext;
  logic [ERR_W-2:0]          smp_ext;
  logic signed [ERR_W-1:0]   error;
  logic signed [PROD_W-1:0]  prop_prod_d, prop_prod_q;
  logic signed [PROD_W-1:0]  int_prod_d, int_prod_q;

  // Signed error, setpoint minus sample, and its two products.
  always_comb begin
    sp_ext      = (ERR_W-1)'(cfg_i.setpoint);
    smp_ext     = (ERR_W-1)'(sample_i);
    error       = $signed({1'b0, sp_ext}) - $signed({1'b0, smp_ext});
    prop_prod_d = error * cfg_i.prop_gain;
    int_prod_d  = error * cfg_i.integral_gain;
  end

  // Product registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prop_prod_q <= prop_prod_d;
      int_prod_q  <= int_prod_d;
    end
  end

  assign prop_prod_o = prop_prod_q;
  assign int_prod_o  = int_prod_q;

endmodule

[hdl/pir_integral_stage.sv]
// Second pipeline stage: integrator update with clamping.
// Depends on pir_pkg and pir_trunc_clamp.
module pir_integral_stage import pir_pkg::*; #(
  parameter int PROD_W    = 29,
  parameter int ACC_W     = 30,
  parameter int FRAC_BITS = 12
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic signed [PROD_W-1:0] int_prod_i,
  input  logic signed [PROD_W-1:0] prop_prod_i,
  input  logic [LIMIT_W-1:0]       out_min_i,
  input  logic [LIMIT_W-1:0]       out_max_i,
  output logic signed [PROD_W-1:0] prop_prod_o,
  output logic [LIMIT_W-1:0]       integral_o
);

  logic [LIMIT_W-1:0]       integral_q, integral_d;
  logic signed [PROD_W-1:0] prop_prod_q;
  logic signed [ACC_W-1:0]  acc;

  // Integral term aligned to the gain fraction plus the new increment.
  always_comb begin
    acc = $signed(ACC_W'({integral_q, {FRAC_BITS{1'b0}}}))
        + $signed({{(ACC_W-PROD_W){int_prod_i[PROD_W-1]}}, int_prod_i});
  end

  pir_trunc_clamp #(
    .ACC_W     (ACC_W),
    .FRAC_BITS (FRAC_BITS)
  ) u_clamp (
    .acc_i     (acc),
    .out_min_i (out_min_i),
    .out_max_i (out_max_i),
    .value_o   (integral_d)
  );

  // The integrator is state and is cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integral_q <= '0;
    end else if (en_i) begin
      integral_q <= integral_d;
    end
  end

  // The proportional product travels along with its request.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prop_prod_q <= prop_prod_i;
    end
  end

  assign prop_prod_o = prop_prod_q;
  assign integral_o  = integral_q;

endmodule

[hdl/pir_drive_stage.sv]
// Output stage: drive value from the proportional product and new integral.
// Depends on pir_pkg and pir_trunc_clamp.
module pir_drive_stage import pir_pkg::*; #(
  parameter int PROD_W    = 29,
  parameter int ACC_W     = 30,
  parameter int FRAC_BITS = 12
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [PROD_W-1:0] prop_prod_i,
  input  logic [LIMIT_W-1:0]       integral_i,
  input  logic [LIMIT_W-1:0]       out_min_i,
  input  logic [LIMIT_W-1:0]       out_max_i,
  output logic [LIMIT_W-1:0]       drive_o
);

  logic [LIMIT_W-1:0]      drive_q, drive_d;
  logic signed [ACC_W-1:0] acc;

  // Proportional product plus the freshly updated integral term.
  always_comb begin
    acc = $signed({{(ACC_W-PROD_W){prop_prod_i[PROD_W-1]}}, prop_prod_i})
        + $signed(ACC_W'({integral_i, {FRAC_BITS{1'b0}}}));
  end

  pir_trunc_clamp #(
    .ACC_W     (ACC_W),
    .FRAC_BITS (FRAC_BITS)
  ) u_clamp (
    .acc_i     (acc),
    .out_min_i (out_min_i),
    .out_max_i (out_max_i),
    .value_o   (drive_d)
  );

  // Result register feeding the output port.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      drive_q <= drive_d;
    end
  end

  assign drive_o = drive_q;

endmodule

[hdl/pi_regulator_clamped_unit.sv]
// Clamped PI regulator: one drive value per sensed sample.
// A sample passes the input, product, integrator and drive registers in that order.
// Throughput: one sample per cycle while drive_ready_i does not stall the output, set by
// a four-register pipeline (input, products, integrator, drive) whose integrator update
// closes in a single stage. Reset: registers return to their defaults, the integrator clears, the pipeline empties.
// Depends on pir_pkg, pir_cfg_regs, pir_product_stage, pir_integral_stage, pir_drive_stage.
module pi_regulator_clamped_unit import pir_pkg::*; #(
  parameter int SAMPLE_BITS    = 12,
  parameter int GAIN_FRAC_BITS = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                   sample_valid_i,
  output logic                   sample_ready_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic                   drive_valid_o,
  input  logic                   drive_ready_i,
  output logic [LIMIT_W-1:0]     drive_o
);

  localparam int ERR_W   = ((SAMPLE_BITS > LIMIT_W) ? SAMPLE_BITS : LIMIT_W) + 1;
  localparam int PROD_W  = GAIN_W + ERR_W;
  localparam int SHIFT_W = LIMIT_W + GAIN_FRAC_BITS + 1;
  localparam int ACC_W   = ((PROD_W > SHIFT_W) ? PROD_W : SHIFT_W) + 1;

  cfg_t                     cfg;
  logic [SAMPLE_BITS-1:0]   sample_q;
  logic                     v0_q, v1_q, v2_q, v3_q;
  logic                     v0_d, v1_d, v2_d, v3_d;
  logic                     ld0, ld1, ld2, ld3;
  logic                     free0, free1, free2, free3;
  logic signed [PROD_W-1:0] prop_prod_s1, int_prod_s1, prop_prod_s2;
  logic [LIMIT_W-1:0]       integral_s2;

  pir_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Each stage loads when it holds nothing or its request moves on.
  always_comb begin
    free3 = !v3_q || drive_ready_i;
    ld3   = v2_q && free3;
    free2 = !v2_q || ld3;
    ld2   = v1_q && free2;
    free1 = !v1_q || ld2;
    ld1   = v0_q && free1;
    free0 = !v0_q || ld1;
    ld0   = sample_valid_i && free0;
    v0_d  = ld0 || (v0_q && !ld1);
    v1_d  = ld1 || (v1_q && !ld2);
    v2_d  = ld2 || (v2_q && !ld3);
    v3_d  = ld3 || (v3_q && !drive_ready_i);
  end

  // Stage occupancy flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v0_q <= v0_d;
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  // Input register.
  always_ff @(posedge clk_i) begin
    if (ld0) begin
      sample_q <= sample_i;
    end
  end

  pir_product_stage #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ERR_W       (ERR_W),
    .PROD_W      (PROD_W)
  ) u_product (
    .clk_i       (clk_i),
    .en_i        (ld1),
    .sample_i    (sample_q),
    .cfg_i       (cfg),
    .prop_prod_o (prop_prod_s1),
    .int_prod_o  (int_prod_s1)
  );

  pir_integral_stage #(
    .PROD_W    (PROD_W),
    .ACC_W     (ACC_W),
    .FRAC_BITS (GAIN_FRAC_BITS)
  ) u_integral (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (ld2),
    .int_prod_i  (int_prod_s1),
    .prop_prod_i (prop_prod_s1),
    .out_min_i   (cfg.out_min),
    .out_max_i   (cfg.out_max),
    .prop_prod_o (prop_prod_s2),
    .integral_o  (integral_s2)
  );

  pir_drive_stage #(
    .PROD_W    (PROD_W),
    .ACC_W     (ACC_W),
    .FRAC_BITS (GAIN_FRAC_BITS)
  ) u_drive (
    .clk_i       (clk_i),
    .en_i        (ld3),
    .prop_prod_i (prop_prod_s2),
    .integral_i  (integral_s2),
    .out_min_i   (cfg.out_min),
    .out_max_i   (cfg.out_max),
    .drive_o     (drive_o)
  );

  assign sample_ready_o = free0;
  assign drive_valid_o  = v3_q;

`ifndef SYNTHESIS
  // Occupancy grows by accepted samples and shrinks by delivered drives.
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |->
    $countones({v0_q, v1_q, v2_q, v3_q}) ==
      $countones($past({v0_q, v1_q, v2_q, v3_q}))
      + $past(ld0) - $past(v3_q && drive_ready_i))
    else $error("pipeline occupancy does not match accepted and delivered requests");

  // An empty output register means the input side is always open.
  a_ready_when_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !drive_valid_o |-> sample_ready_o)
    else $error("input blocked while the output register is free");

  // Input stalls only when every stage is full and the output is held.
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sample_ready_o |-> (v0_q && v1_q && v2_q && v3_q && !drive_ready_i))
    else $error("input stalled with room left in the pipeline");
`endif

endmodule
